/* rtl/core/bfs_pkg.sv */
package bfs_pkg;

   localparam int WORD_BITS  = 64;
   localparam int MAX_BITS   = 4096;
   localparam int FRAC_BITS  = 16;
   localparam int LANES      = 4;
   localparam int LANE_BITS  = WORD_BITS / LANES;
   localparam int LANE_CNT_W = $clog2(LANE_BITS + 1);
   localparam int WORD_CNT_W = $clog2(WORD_BITS + 1);
   localparam int WORD_SHIFT = $clog2(WORD_BITS);
   localparam int CNT_W      = 13;
   localparam int POS_W      = 7;
   localparam int POS_LIMIT  = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int SCORE_W    = FRAC_BITS + 1;
   localparam int NUM_W      = 32;
   localparam int COEFF_W    = 16;
   localparam int PROD_W     = COEFF_W + CNT_W;
   localparam int MUL_STEPS  = 5;
   localparam int MUL_IDX_W  = $clog2(MUL_STEPS);
   localparam int ADDR_W     = 5;

   localparam logic [SCORE_W-1:0] SCORE_ONE = SCORE_W'(1) << FRAC_BITS;

   localparam logic [2:0] CSR_METRIC    = 3'd0;
   localparam logic [2:0] CSR_ALPHA     = 3'd1;
   localparam logic [2:0] CSR_BETA      = 3'd2;
   localparam logic [2:0] CSR_ZERO_SENS = 3'd3;
   localparam logic [2:0] CSR_LENGTH    = 3'd4;

   typedef enum logic [2:0] {
      MET_TANIMOTO,
      MET_TVERSKY,
      MET_OPTIMISTIC,
      MET_RUSSELL_RAO,
      MET_FORBES,
      MET_SIMPLE_MATCH,
      MET_DICE,
      MET_OVERLAP
   } metric_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MULT,
      ST_PLAN,
      ST_LOAD,
      ST_START,
      ST_WAIT,
      ST_DONE
   } score_state_type;

   typedef struct packed {
      logic [LANE_CNT_W-1:0] first;
      logic [LANE_CNT_W-1:0] second;
      logic [LANE_CNT_W-1:0] both;
   } lane_cnt_type;

   typedef struct packed {
      logic [WORD_CNT_W-1:0] first;
      logic [WORD_CNT_W-1:0] second;
      logic [WORD_CNT_W-1:0] both;
   } word_cnt_type;

   typedef struct packed {
      logic [CNT_W-1:0] first;
      logic [CNT_W-1:0] second;
      logic [CNT_W-1:0] both;
   } counts_type;

   typedef struct packed {
      metric_type         metric;
      logic [COEFF_W-1:0] alpha;
      logic [COEFF_W-1:0] beta;
      logic               zero_sens;
      logic [CNT_W-1:0]   length;
   } cfg_type;

   typedef struct packed {
      logic [SCORE_W-1:0] score;
      logic [CNT_W-1:0]   common;
      logic               zero_den;
   } result_type;

endpackage

/* rtl/core/bfs_lane.sv */
module bfs_lane (
   input  logic [bfs_pkg::LANE_BITS-1:0] first,
   input  logic [bfs_pkg::LANE_BITS-1:0] second,
   output bfs_pkg::lane_cnt_type         cnt
);
   import bfs_pkg::*;

   always_comb begin
      cnt.first  = LANE_CNT_W'($countones(first));
      cnt.second = LANE_CNT_W'($countones(second));
      cnt.both   = LANE_CNT_W'($countones(first & second));
   end

endmodule

/* rtl/core/bfs_merge.sv */
module bfs_merge (
   input  bfs_pkg::lane_cnt_type lanes [bfs_pkg::LANES],
   output bfs_pkg::word_cnt_type total
);
   import bfs_pkg::*;

   always_comb begin
      total = '0;
      for (int l = 0; l < LANES; l++) begin
         total.first  = total.first  + WORD_CNT_W'(lanes[l].first);
         total.second = total.second + WORD_CNT_W'(lanes[l].second);
         total.both   = total.both   + WORD_CNT_W'(lanes[l].both);
      end
   end

endmodule

/* rtl/core/bfs_div.sv */
module bfs_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [bfs_pkg::NUM_W-1:0]    num,
   input  logic [bfs_pkg::NUM_W-1:0]    den,
   output logic                         done,
   output logic                         zero_den,
   output logic [bfs_pkg::SCORE_W-1:0]  quot
);
   import bfs_pkg::*;

   localparam int DIV_W  = NUM_W + FRAC_BITS;
   localparam int STEP_W = $clog2(SCORE_W + 1);

   logic [DIV_W-1:0]     dividend;
   logic [NUM_W:0]       trial;
   logic                 fits;
   logic [NUM_W-1:0]     rem_ff, rem_in;
   logic [SCORE_W-1:0]   lo_ff, lo_in;
   logic [NUM_W-1:0]     den_ff;
   logic [STEP_W-1:0]    cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic                 zd_ff;
   logic [SCORE_W-1:0]   quot_ff;

   // round to nearest: (num << frac + den/2) / den
   // with num < den the top bits above the quotient stay below den, and the
   // quotient can round up to exactly 1.0, so all score bits are produced
   assign dividend = {num, FRAC_BITS'(0)} + DIV_W'(den >> 1);
   assign trial    = {rem_ff, lo_ff[SCORE_W-1]};
   assign fits     = trial >= {1'b0, den_ff};
   assign rem_in   = fits ? NUM_W'(trial - {1'b0, den_ff}) : trial[NUM_W-1:0];
   assign lo_in    = {lo_ff[SCORE_W-2:0], fits};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            if (den == '0) begin
               done_ff <= 1'b1;
               zd_ff   <= 1'b1;
               quot_ff <= '0;
            end else if (num >= den) begin
               done_ff <= 1'b1;
               zd_ff   <= 1'b0;
               quot_ff <= SCORE_ONE;
            end else begin
               busy_ff <= 1'b1;
               zd_ff   <= 1'b0;
               rem_ff  <= NUM_W'(dividend[DIV_W-1:SCORE_W]);
               lo_ff   <= dividend[SCORE_W-1:0];
               den_ff  <= den;
               cnt_ff  <= STEP_W'(SCORE_W);
            end
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            lo_ff  <= lo_in;
            cnt_ff <= cnt_ff - STEP_W'(1);
            if (cnt_ff == STEP_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
               quot_ff <= lo_in;
            end
         end
      end
   end

   assign done     = done_ff;
   assign zero_den = zd_ff;
   assign quot     = quot_ff;

endmodule

/* rtl/core/bfs_score.sv */
module bfs_score (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  bfs_pkg::counts_type   counts,
   input  bfs_pkg::cfg_type      cfg,
   input  logic                  result_take,
   output logic                  busy,
   output logic                  result_valid,
   output bfs_pkg::result_type   result
);
   import bfs_pkg::*;

   localparam logic [MUL_IDX_W-1:0] MUL_ALPHA_A = MUL_IDX_W'(0);
   localparam logic [MUL_IDX_W-1:0] MUL_BETA_B  = MUL_IDX_W'(1);
   localparam logic [MUL_IDX_W-1:0] MUL_BETA_A  = MUL_IDX_W'(2);
   localparam logic [MUL_IDX_W-1:0] MUL_ALPHA_B = MUL_IDX_W'(3);
   localparam logic [MUL_IDX_W-1:0] MUL_NA_NB   = MUL_IDX_W'(4);

   score_state_type state_ff, state_in;

   logic [CNT_W-1:0]     na_ff, nb_ff, c_ff;
   logic [CNT_W-1:0]     only_a, only_b;
   logic [MUL_IDX_W-1:0] mul_cnt_ff;
   logic [PROD_W-1:0]    prod_ff [MUL_STEPS];
   logic [COEFF_W-1:0]   mul_a;
   logic [CNT_W-1:0]     mul_b;
   logic [PROD_W-1:0]    mul_out;

   logic               alt_ff, comp_ff, zd_ff;
   logic [1:0]         ridx_ff, nratio_ff;
   logic [SCORE_W-1:0] best_ff, score_ff;
   logic [NUM_W-1:0]   num_ff, den_ff;

   logic               plan_special, plan_alt, plan_comp;
   logic [1:0]         plan_nr;
   logic [SCORE_W-1:0] plan_score;
   logic               empty_any, empty_both, no_common;

   logic [NUM_W-1:0]   num_sel, den_sel;
   logic [NUM_W-1:0]   c_shift, den_tv1, den_tv2, den_tan, sum_ab, len_w, sm_lhs;

   logic               div_start, div_done, div_zd;
   logic [SCORE_W-1:0] div_q, best_new, final_score;
   logic               zd_new, last_ratio;

   assign only_a = (na_ff > c_ff) ? na_ff - c_ff : '0;
   assign only_b = (nb_ff > c_ff) ? nb_ff - c_ff : '0;

   // one shared multiplier, one product a cycle
   always_comb begin
      unique case (mul_cnt_ff)
         MUL_ALPHA_A: begin mul_a = cfg.alpha; mul_b = only_a; end
         MUL_BETA_B:  begin mul_a = cfg.beta;  mul_b = only_b; end
         MUL_BETA_A:  begin mul_a = cfg.beta;  mul_b = only_a; end
         MUL_ALPHA_B: begin mul_a = cfg.alpha; mul_b = only_b; end
         MUL_NA_NB:   begin mul_a = COEFF_W'(na_ff); mul_b = nb_ff; end
         default:     begin mul_a = '0; mul_b = '0; end
      endcase
   end
   assign mul_out = PROD_W'(mul_a) * PROD_W'(mul_b);

   assign empty_any  = (na_ff == '0) || (nb_ff == '0);
   assign empty_both = (na_ff == '0) && (nb_ff == '0);
   assign no_common  = (c_ff == '0);

   // special cases settle the score without a division
   always_comb begin
      plan_special = 1'b0;
      plan_score   = '0;
      plan_alt     = 1'b0;
      plan_comp    = 1'b0;
      plan_nr      = 2'd1;
      unique case (cfg.metric)
         MET_TANIMOTO: begin
            if (no_common) begin
               plan_special = 1'b1;
               plan_score   = empty_both ? SCORE_ONE : '0;
            end
         end
         MET_TVERSKY: begin
            if (empty_both) begin
               plan_special = 1'b1;
               plan_score   = SCORE_ONE;
            end else if (empty_any && !cfg.zero_sens) begin
               plan_special = 1'b1;
            end else if (empty_any) begin
               plan_alt = 1'b1;
            end
         end
         MET_OPTIMISTIC: begin
            if (empty_both) begin
               plan_special = 1'b1;
            end else if (empty_any && !cfg.zero_sens) begin
               plan_special = 1'b1;
               plan_score   = SCORE_ONE;
            end else if (empty_any) begin
               plan_alt = 1'b1;
            end else if (no_common) begin
               plan_special = 1'b1;
               plan_score   = SCORE_ONE;
            end else begin
               plan_nr   = 2'd3;
               plan_comp = 1'b1;
            end
         end
         MET_RUSSELL_RAO: plan_special = empty_any;
         MET_FORBES:      plan_special = empty_any || no_common;
         MET_SIMPLE_MATCH: ;
         MET_DICE:        plan_comp = 1'b1;
         MET_OVERLAP: begin
            if (no_common) begin
               plan_special = 1'b1;
               plan_score   = SCORE_ONE;
            end else begin
               plan_comp = 1'b1;
            end
         end
         default: ;
      endcase
   end

   assign c_shift = NUM_W'(c_ff) << 8;
   assign den_tv1 = NUM_W'(prod_ff[MUL_ALPHA_A]) + NUM_W'(prod_ff[MUL_BETA_B]) + c_shift;
   assign den_tv2 = NUM_W'(prod_ff[MUL_BETA_A]) + NUM_W'(prod_ff[MUL_ALPHA_B]) + c_shift;
   assign sum_ab  = NUM_W'(na_ff) + NUM_W'(nb_ff);
   assign den_tan = sum_ab - NUM_W'(c_ff);
   assign len_w   = NUM_W'(cfg.length);
   assign sm_lhs  = len_w + (NUM_W'(c_ff) << 1);

   always_comb begin
      num_sel = NUM_W'(c_ff);
      den_sel = den_tan;
      if (alt_ff) begin
         // one side empty: sum is the other side's count
         num_sel = (cfg.metric == MET_TVERSKY) ? NUM_W'(1) : sum_ab;
         den_sel = sum_ab + NUM_W'(1);
      end else begin
         unique case (cfg.metric)
            MET_TANIMOTO: ;
            MET_TVERSKY: begin num_sel = c_shift; den_sel = den_tv1; end
            MET_OPTIMISTIC: begin
               if (ridx_ff == 2'd0) begin
                  num_sel = c_shift;
                  den_sel = den_tv1;
               end else if (ridx_ff == 2'd1) begin
                  num_sel = c_shift;
                  den_sel = den_tv2;
               end
            end
            MET_RUSSELL_RAO: den_sel = len_w;
            MET_FORBES:      den_sel = NUM_W'(prod_ff[MUL_NA_NB]);
            MET_SIMPLE_MATCH: begin
               num_sel = (sm_lhs >= sum_ab) ? sm_lhs - sum_ab : NUM_W'(c_ff);
               den_sel = len_w;
            end
            MET_DICE: begin
               num_sel = NUM_W'(c_ff) << 1;
               den_sel = sum_ab;
            end
            MET_OVERLAP: den_sel = NUM_W'((na_ff < nb_ff) ? na_ff : nb_ff);
            default: ;
         endcase
      end
   end

   bfs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (num_ff),
      .den      (den_ff),
      .done     (div_done),
      .zero_den (div_zd),
      .quot     (div_q)
   );

   assign best_new    = (div_q > best_ff) ? div_q : best_ff;
   assign zd_new      = zd_ff | div_zd;
   assign last_ratio  = (ridx_ff + 2'd1) == nratio_ff;
   assign final_score = zd_new ? '0 : (comp_ff ? SCORE_ONE - best_new : best_new);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (start) state_in = ST_MULT;
         ST_MULT:  if (mul_cnt_ff == MUL_IDX_W'(MUL_STEPS - 1)) state_in = ST_PLAN;
         ST_PLAN:  state_in = plan_special ? ST_DONE : ST_LOAD;
         ST_LOAD:  state_in = ST_START;
         ST_START: state_in = ST_WAIT;
         ST_WAIT:  if (div_done) state_in = last_ratio ? ST_DONE : ST_LOAD;
         ST_DONE:  if (result_take) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      busy         = (state_ff != ST_IDLE);
      div_start    = (state_ff == ST_START);
      result_valid = (state_ff == ST_DONE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               na_ff <= counts.first;
               nb_ff <= counts.second;
               c_ff  <= counts.both;
            end
            mul_cnt_ff <= '0;
         end
         ST_MULT: begin
            prod_ff[mul_cnt_ff] <= mul_out;
            mul_cnt_ff          <= mul_cnt_ff + MUL_IDX_W'(1);
         end
         ST_PLAN: begin
            score_ff  <= plan_score;
            zd_ff     <= 1'b0;
            best_ff   <= '0;
            ridx_ff   <= '0;
            nratio_ff <= plan_nr;
            comp_ff   <= plan_comp;
            alt_ff    <= plan_alt;
         end
         ST_LOAD: begin
            num_ff <= num_sel;
            den_ff <= den_sel;
         end
         ST_WAIT: begin
            if (div_done) begin
               best_ff  <= best_new;
               zd_ff    <= zd_new;
               ridx_ff  <= ridx_ff + 2'd1;
               score_ff <= final_score;
            end
         end
         default: ;
      endcase
   end

   assign result.score    = score_ff;
   assign result.common   = c_ff;
   assign result.zero_den = zd_ff;

endmodule

/* rtl/core/binary_fingerprint_similarity.sv */
// fingerprint similarity engine: two bit fingerprints stream in as paired 64-bit words, one
// transfer a cycle while req_stall is low, with req_last_word on the final pair; bits at or
// past length_bits (capped at 4096) are masked off. four popcount lanes count each word and a
// merge stage adds them into the running set counts of both fingerprints and their common
// count. the last word starts the scoring sequencer, which holds req_stall high until the
// score is handed to the rsp register: five products on a shared 16x13 multiplier, a planning
// step, then per ratio a load and a start state plus the serial divider, which makes one
// quotient bit a cycle. most metrics take a single ratio, optimistic distance three, and
// special cases such as empty fingerprints skip the divider. scores are unsigned q1.16 with
// 65536 for 1.0, ratios rounded to nearest; a zero denominator gives score 0 and sets
// rsp_zero_denominator. registers on the csr port at byte addresses 0 metric, 4 alpha_coeff,
// 8 beta_coeff, 12 zero_bit_sensitive, 16 length_bits; write them only while no fingerprint is
// in flight
module binary_fingerprint_similarity (
   input  logic                               clock,
   input  logic                               reset,
   // input channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [63:0]                        req_word_first,
   input  logic [63:0]                        req_word_second,
   input  logic                               req_last_word,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [16:0]                        rsp_score,
   output logic [12:0]                        rsp_bits_common,
   output logic                               rsp_zero_denominator,
   // configuration
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [bfs_pkg::ADDR_W-1:0]         csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);
   import bfs_pkg::*;

   // configuration registers
   metric_type         metric_ff;
   logic [COEFF_W-1:0] alpha_ff, beta_ff;
   logic               zero_sens_ff;
   logic [CNT_W-1:0]   length_ff;
   logic               csr_write;
   logic [2:0]         csr_index;

   // running counts for the fingerprint pair in flight
   counts_type         count_ff, count_in;
   logic [POS_W-1:0]   pos_ff;

   logic                  req_take;
   logic [CNT_W-1:0]      len_eff, word_base, avail;
   logic [WORD_CNT_W-1:0] valid_bits;
   logic [WORD_BITS-1:0]  mask, w_first, w_second;
   lane_cnt_type          lane_cnt [LANES];
   word_cnt_type          word_cnt;

   cfg_type    cfg;
   logic       eng_busy, eng_valid, eng_take, eng_start;
   result_type eng_result;

   // result register, parts the engine from the rsp side
   logic       rsp_valid_ff;
   result_type rsp_ff;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         metric_ff    <= MET_TANIMOTO;
         alpha_ff     <= COEFF_W'(256);
         beta_ff      <= COEFF_W'(256);
         zero_sens_ff <= 1'b0;
         length_ff    <= CNT_W'(2048);
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_METRIC:    metric_ff    <= metric_type'(csr_pwdata[2:0]);
            CSR_ALPHA:     alpha_ff     <= csr_pwdata[COEFF_W-1:0];
            CSR_BETA:      beta_ff      <= csr_pwdata[COEFF_W-1:0];
            CSR_ZERO_SENS: zero_sens_ff <= csr_pwdata[0];
            CSR_LENGTH:    length_ff    <= csr_pwdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         CSR_METRIC:    csr_prdata = 32'(metric_ff);
         CSR_ALPHA:     csr_prdata = 32'(alpha_ff);
         CSR_BETA:      csr_prdata = 32'(beta_ff);
         CSR_ZERO_SENS: csr_prdata = 32'(zero_sens_ff);
         CSR_LENGTH:    csr_prdata = 32'(length_ff);
         default:       csr_prdata = '0;
      endcase
   end

   // lengths above the maximum act as the maximum
   assign len_eff = (length_ff > CNT_W'(MAX_BITS)) ? CNT_W'(MAX_BITS) : length_ff;

   assign cfg.metric    = metric_ff;
   assign cfg.alpha     = alpha_ff;
   assign cfg.beta      = beta_ff;
   assign cfg.zero_sens = zero_sens_ff;
   assign cfg.length    = len_eff;

   // no new word while a score is being worked out
   assign req_stall = eng_busy;
   assign req_take  = req_valid && !req_stall;

   // mask off bits at or past the configured length
   assign word_base  = CNT_W'(pos_ff) << WORD_SHIFT;
   assign avail      = (word_base >= len_eff) ? '0 : len_eff - word_base;
   assign valid_bits = (avail > CNT_W'(WORD_BITS)) ? WORD_CNT_W'(WORD_BITS)
                                                   : avail[WORD_CNT_W-1:0];

   always_comb begin
      for (int k = 0; k < WORD_BITS; k++) begin
         mask[k] = WORD_CNT_W'(k) < valid_bits;
      end
   end

   assign w_first  = req_word_first  & mask;
   assign w_second = req_word_second & mask;

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      bfs_lane u_lane (
         .first  (w_first[l*LANE_BITS +: LANE_BITS]),
         .second (w_second[l*LANE_BITS +: LANE_BITS]),
         .cnt    (lane_cnt[l])
      );
   end

   bfs_merge u_merge (
      .lanes (lane_cnt),
      .total (word_cnt)
   );

   always_comb begin
      count_in.first  = count_ff.first  + CNT_W'(word_cnt.first);
      count_in.second = count_ff.second + CNT_W'(word_cnt.second);
      count_in.both   = count_ff.both   + CNT_W'(word_cnt.both);
   end

   assign eng_start = req_take && req_last_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         pos_ff   <= '0;
      end else if (req_take) begin
         if (req_last_word) begin
            // counts go to the engine, start over for the next pair
            count_ff <= '0;
            pos_ff   <= '0;
         end else begin
            count_ff <= count_in;
            if (pos_ff < POS_W'(POS_LIMIT)) begin
               pos_ff <= pos_ff + POS_W'(1);
            end
         end
      end
   end

   bfs_score u_score (
      .clock        (clock),
      .reset        (reset),
      .start        (eng_start),
      .counts       (count_in),
      .cfg          (cfg),
      .result_take  (eng_take),
      .busy         (eng_busy),
      .result_valid (eng_valid),
      .result       (eng_result)
   );

   // engine result moves into the rsp register once it is free or draining
   assign eng_take = eng_valid && (!rsp_valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (eng_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (eng_take) begin
         rsp_ff <= eng_result;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_score            = rsp_ff.score;
   assign rsp_bits_common      = rsp_ff.common;
   assign rsp_zero_denominator = rsp_ff.zero_den;

endmodule

/* rtl/core/bfs_checker.sv */
module bfs_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [16:0] rsp_score,
   input logic [12:0] rsp_bits_common,
   input logic        rsp_zero_denominator
);
   import bfs_pkg::*;

   // no result straight out of reset
   a_reset_quiet: assert property (@(posedge clock) !reset && $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled result dropped");

   a_score_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_score <= 17'(SCORE_ONE))
      else $error("score above one");

   a_zero_den: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_denominator |-> rsp_score == '0)
      else $error("nonzero score with zero denominator");

   a_common_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_bits_common <= 13'(MAX_BITS))
      else $error("common count above maximum length");

endmodule

bind binary_fingerprint_similarity bfs_checker u_bfs_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_score            (rsp_score),
   .rsp_bits_common      (rsp_bits_common),
   .rsp_zero_denominator (rsp_zero_denominator)
);

/* tb/tb_binary_fingerprint_similarity.sv */
`timescale 1ns / 100ps

module tb_binary_fingerprint_similarity;
   import bfs_pkg::*;

   // one expected result of a fingerprint pair
   typedef struct {
      logic [16:0] score;
      logic [12:0] common;
      logic        zero_den;
   } score_rec;

   // predicts the score of each fingerprint pair and checks the results in order
   class similarity_ledger;
      metric_type  metric;
      int unsigned alpha, beta, zero_sens, length;
      int unsigned cnt_a, cnt_b, cnt_c, position;
      score_rec    expected_scores[$];
      int          errors;

      function new();
         metric    = MET_TANIMOTO;
         alpha     = 256;
         beta      = 256;
         zero_sens = 0;
         length    = 2048;
         cnt_a     = 0;
         cnt_b     = 0;
         cnt_c     = 0;
         position  = 0;
         errors    = 0;
      endfunction

      function void set_reg(int idx, int unsigned v);
         case (idx)
            CSR_METRIC:    metric    = metric_type'(v[2:0]);
            CSR_ALPHA:     alpha     = v & 16'hFFFF;
            CSR_BETA:      beta      = v & 16'hFFFF;
            CSR_ZERO_SENS: zero_sens = v & 1;
            CSR_LENGTH:    length    = v & 13'h1FFF;
            default: ;
         endcase
      endfunction

      // rounded num/den in q1.16, saturating at 1.0
      function longint unsigned frac(longint unsigned num, longint unsigned den,
                                     ref bit zd);
         if (den == 0) begin
            zd = 1;
            return 0;
         end
         if (num >= den) return 64'd1 << FRAC_BITS;
         return ((num << FRAC_BITS) + den / 2) / den;
      endfunction

      function longint unsigned score_of(ref bit zd);
         longint unsigned na, nb, c, len, a, b, one, t1, t2, t3, best, n, num, s;
         bit dummy;
         na   = cnt_a;
         nb   = cnt_b;
         c    = cnt_c;
         len  = (length > MAX_BITS) ? MAX_BITS : length;
         a    = (na > c) ? na - c : 0;
         b    = (nb > c) ? nb - c : 0;
         one  = 64'd1 << FRAC_BITS;
         dummy = 0;
         case (metric)
            MET_TANIMOTO: begin
               if (c == 0) return (na == 0 && nb == 0) ? one : 0;
               return frac(c, na + nb - c, zd);
            end
            MET_TVERSKY: begin
               if (na == 0 || nb == 0) begin
                  if (na == 0 && nb == 0) return one;
                  if (zero_sens == 0) return 0;
                  return frac(1, ((na != 0) ? na : nb) + 1, zd);
               end
               return frac(c << 8, alpha * a + beta * b + (c << 8), zd);
            end
            MET_OPTIMISTIC: begin
               if (na == 0 || nb == 0) begin
                  n = (na != 0) ? na : nb;
                  if (na == nb) return 0;
                  if (zero_sens == 0) return one;
                  return frac(n, n + 1, zd);
               end
               if (c == 0) return one;
               t1 = frac(c << 8, alpha * a + beta * b + (c << 8), dummy);
               t2 = frac(c << 8, beta * a + alpha * b + (c << 8), dummy);
               t3 = frac(c, na + nb - c, dummy);
               best = t1;
               if (t2 > best) best = t2;
               if (t3 > best) best = t3;
               return one - best;
            end
            MET_RUSSELL_RAO: begin
               if (na == 0 || nb == 0) return 0;
               return frac(c, len, zd);
            end
            MET_FORBES: begin
               if (na == 0 || nb == 0 || c == 0) return 0;
               return frac(c, na * nb, zd);
            end
            MET_SIMPLE_MATCH: begin
               num = (len + 2 * c >= na + nb) ? len + 2 * c - na - nb : c;
               return frac(num, len, zd);
            end
            MET_DICE: begin
               s = frac(2 * c, na + nb, zd);
               if (zd) return 0;
               return one - s;
            end
            default: begin
               if (c == 0) return one;
               return one - frac(c, (na < nb) ? na : nb, zd);
            end
         endcase
      endfunction

      // one accepted word pair
      function void note_word(logic [63:0] w1, logic [63:0] w2, logic last);
         int unsigned     base, len, valid_bits;
         logic [63:0]     mask, m1, m2;
         longint unsigned sc;
         bit              zd;
         score_rec        r;
         base = position * WORD_BITS;
         len  = (length > MAX_BITS) ? MAX_BITS : length;
         valid_bits = (base >= len) ? 0 : len - base;
         if (valid_bits > 64) valid_bits = 64;
         mask = (valid_bits == 0) ? 64'd0 : ({64{1'b1}} >> (64 - valid_bits));
         m1 = w1 & mask;
         m2 = w2 & mask;
         cnt_a = (cnt_a + $countones(m1)) & 13'h1FFF;
         cnt_b = (cnt_b + $countones(m2)) & 13'h1FFF;
         cnt_c = (cnt_c + $countones(m1 & m2)) & 13'h1FFF;
         if (position < POS_LIMIT) position++;
         if (!last) return;
         zd = 0;
         sc = score_of(zd);
         if (zd) sc = 0;
         r.score    = sc[16:0];
         r.common   = cnt_c[12:0];
         r.zero_den = zd;
         expected_scores.push_back(r);
         cnt_a    = 0;
         cnt_b    = 0;
         cnt_c    = 0;
         position = 0;
      endfunction

      task report(string what);
         errors++;
         $display("mismatch at %0t: %s", $realtime, what);
      endtask

      task check_score(logic [16:0] score, logic [12:0] common, logic zd);
         score_rec e;
         if (expected_scores.size() == 0) begin
            report($sformatf("unexpected result score=%0d common=%0d", score, common));
            return;
         end
         e = expected_scores.pop_front();
         if (score !== e.score)
            report($sformatf("score %0d, expected %0d", score, e.score));
         if (common !== e.common)
            report($sformatf("bits_common %0d, expected %0d", common, e.common));
         if (zd !== e.zero_den)
            report($sformatf("zero_denominator %0b, expected %0b", zd, e.zero_den));
      endtask
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [63:0] req_word_first = 0;
   logic [63:0] req_word_second = 0;
   logic        req_last_word = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [16:0] rsp_score;
   logic [12:0] rsp_bits_common;
   logic        rsp_zero_denominator;
   logic        csr_psel = 0;
   logic        csr_penable = 0;
   logic        csr_pwrite = 0;
   logic [ADDR_W-1:0] csr_paddr = 0;
   logic [31:0] csr_pwdata = 0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   similarity_ledger ledger = new();
   int          words_sent = 0;
   int          cycles = 0;
   bit          quiet = 0;     // no idling near the end
   logic        hold_req = 0;  // asks the receiver for one long hold-off

   binary_fingerprint_similarity dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // run limit, far above the slowest correct run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 3000000) begin
         $display("tb: failure");
         $finish;
      end
   end

   // receiver side: random stall bursts plus one long hold-off so the block backs up
   int  stall_left = 0;
   int  hold_left = 0;
   bit  held = 0;
   always @(posedge clock) begin
      if (hold_req && !held) begin
         held = 1;
         hold_left = 300;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 8) - 1;
         rsp_stall <= 1;
      end else begin
         rsp_stall <= 0;
      end
   end

   // result transfers are judged at the falling edge, where everything is settled
   always @(negedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         ledger.check_score(rsp_score, rsp_bits_common, rsp_zero_denominator);
   end

   task csr_write(logic [2:0] idx, int unsigned v);
      @(posedge clock);
      csr_psel    <= 1;
      csr_pwrite  <= 1;
      csr_penable <= 0;
      csr_paddr   <= ADDR_W'(idx * 4);
      csr_pwdata  <= v;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel    <= 0;
      csr_penable <= 0;
      ledger.set_reg(idx, v);
   endtask

   // one word pair, with an optional gap ahead of it; returns once transferred
   task send_word(logic [63:0] w1, logic [63:0] w2, logic last);
      bit taken;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid       <= 1;
      req_word_first  <= w1;
      req_word_second <= w2;
      req_last_word   <= last;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      ledger.note_word(w1, w2, last);
      words_sent++;
   endtask

   task wait_drained();
      req_valid <= 0;
      while (ledger.expected_scores.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   function logic [63:0] rand_word(int kind);
      logic [63:0] r;
      r = {$urandom(), $urandom()};
      case (kind)
         0: return 64'd0;
         1: return {64{1'b1}};
         2: return r & {$urandom(), $urandom()} & {$urandom(), $urandom()};
         3: return r | {$urandom(), $urandom()};
         default: return r;
      endcase
   endfunction

   // one fingerprint pair of nwords words with random density and pairing
   task send_print(int nwords);
      int          k1, k2, pairing;
      logic [63:0] w1, w2;
      k1      = $urandom_range(0, 6);
      k2      = $urandom_range(0, 6);
      pairing = $urandom_range(0, 5);
      for (int i = 0; i < nwords; i++) begin
         w1 = rand_word(k1);
         case (pairing)
            0: w2 = w1;
            1: w2 = ~w1;               // no common bits
            2: w2 = w1 & rand_word(4); // subset of the first
            default: w2 = rand_word(k2);
         endcase
         send_word(w1, w2, i == nwords - 1);
      end
   endtask

   initial begin
      int unsigned len, eff, nwords, prints;
      int          phase;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: one-word prints over every metric, empty and full cases
      csr_write(CSR_LENGTH, 64);
      csr_write(CSR_ZERO_SENS, 1);
      for (int m = 0; m < 8; m++) begin
         csr_write(CSR_METRIC, m);
         send_word(64'd0, 64'd0, 1);
         send_word({64{1'b1}}, 64'd0, 1);
         send_word(64'h0000_0000_FFFF_FFFF, {64{1'b1}}, 1);
         wait_drained();
      end

      phase = 0;
      while (words_sent < 1900) begin
         phase++;
         wait_drained();
         if (words_sent > 1650) quiet = 1;
         case ($urandom_range(0, 9))
            0: len = 8;
            1: len = 0;
            2: len = 4096;
            3: len = 8191;
            4: len = 64;
            default: len = $urandom_range(8, 700);
         endcase
         csr_write(CSR_METRIC, $urandom_range(0, 7));
         case ($urandom_range(0, 3))
            0: csr_write(CSR_ALPHA, 0);
            1: csr_write(CSR_ALPHA, 65535);
            2: csr_write(CSR_ALPHA, 256);
            default: csr_write(CSR_ALPHA, $urandom_range(0, 65535));
         endcase
         case ($urandom_range(0, 3))
            0: csr_write(CSR_BETA, 0);
            1: csr_write(CSR_BETA, 65535);
            2: csr_write(CSR_BETA, 256);
            default: csr_write(CSR_BETA, $urandom_range(0, 65535));
         endcase
         csr_write(CSR_ZERO_SENS, $urandom_range(0, 1));
         csr_write(CSR_LENGTH, len);
         eff    = (len > MAX_BITS) ? MAX_BITS : len;
         prints = (eff > 1024) ? 2 : $urandom_range(4, 12);
         if (phase == 2) hold_req <= 1;
         for (int p = 0; p < prints; p++) begin
            nwords = (eff + 63) / 64;
            if (nwords == 0) nwords = 1;
            case ($urandom_range(0, 7))
               0: nwords = nwords + 2;  // words past the length, or past the limit
               1: if (nwords > 1) nwords = nwords - 1;
               default: ;
            endcase
            // sender waits for every result once mid-phase
            if (phase == 3 && p == 2) begin
               req_valid <= 0;
               while (ledger.expected_scores.size() != 0) @(posedge clock);
            end
            send_print(nwords);
         end
      end

      wait_drained();
      repeat (50) @(posedge clock);
      if (ledger.errors == 0 && ledger.expected_scores.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
